### sv/srrw_pkg.sv
// ============================================================================
// srrw_pkg
// Shared types and constants for the selective-repeat receive window.
// ============================================================================
package srrw_pkg;

    localparam int WORD_BYTES = 8;
    localparam int WORD_IDX_W = 3;
    localparam int OFS_W      = 31;
    localparam int BYTES_W    = 7;
    localparam int DATA_W     = 64;
    localparam int DBYTES_W   = 4;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 104;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic word_next;
        logic slot_next;
        logic flush_end;
        logic ack_load;
    } cmd_t;

    typedef struct packed {
        logic decide;
        logic flush_req;
        logic word_avail;
        logic last_slot;
        logic out_free;
    } status_t;

endpackage

### sv/selective_repeat_receive_window.sv
// ============================================================================
// selective_repeat_receive_window
// Receive window that reorders packets into slots and flushes them in order.
// ============================================================================
// Each input transfer is one payload word; it is captured in one cycle and
// evaluated in the next. The word that ends a packet also gets an
// acknowledgment or reject result. A flush walks the slots through the
// single read port of the payload memory, emitting the data words of each
// slot in turn, all at the pace the result channel accepts. After the
// final packet has been flushed, transfer_done stays high and further input
// transfers are accepted and dropped until reset.
module selective_repeat_receive_window #(
    parameter int WINDOW_SLOTS = 4,
    parameter int PACKET_BYTES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // seq_offset[30:0], payload_bytes[37:31], is_last_packet[38],
    // word_index[41:39], payload_word[105:42], zero fill above.
    input  logic [srrw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ack_offset[30:0], ack_last[31], data_word[95:32], data_bytes[99:96],
    // transfer_done[100], zero fill above.
    output logic [srrw_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind[1:0].
    output logic [srrw_pkg::KIND_W-1:0]    m_tuser,
    output logic                           m_tlast
);

    srrw_pkg::cmd_t    cmd;
    srrw_pkg::status_t status;

    srrw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srrw_datapath #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### sv/srrw_ctrl.sv
// ============================================================================
// srrw_ctrl
// Controller that sequences capture, evaluation, flush and acknowledgment.
// ============================================================================
module srrw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  srrw_pkg::status_t status,
    output srrw_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FL_CHECK,
        ST_FL_EMIT,
        ST_ACK
    } state_t;

    state_t state_reg;
    logic   tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (tready_reg && s_tvalid) begin
                        state_reg  <= ST_EVAL;
                        tready_reg <= 1'b0;
                    end else begin
                        tready_reg <= 1'b1;
                    end
                end
                ST_EVAL: begin
                    if (!status.decide) begin
                        state_reg  <= ST_IDLE;
                        tready_reg <= 1'b1;
                    end else if (status.flush_req) begin
                        state_reg <= ST_FL_CHECK;
                    end else begin
                        state_reg <= ST_ACK;
                    end
                end
                ST_FL_CHECK: begin
                    if (status.word_avail) begin
                        state_reg <= ST_FL_EMIT;
                    end else if (status.last_slot) begin
                        state_reg <= ST_ACK;
                    end
                end
                ST_FL_EMIT: begin
                    if (status.out_free) begin
                        state_reg <= ST_FL_CHECK;
                    end
                end
                ST_ACK: begin
                    if (status.out_free) begin
                        state_reg  <= ST_IDLE;
                        tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg  <= ST_IDLE;
                    tready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready = tready_reg;

    always_comb begin
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && tready_reg && s_tvalid;
        cmd.evaluate  = (state_reg == ST_EVAL);
        cmd.word_next = (state_reg == ST_FL_EMIT) && status.out_free;
        cmd.slot_next = (state_reg == ST_FL_CHECK) && !status.word_avail
                        && !status.last_slot;
        cmd.flush_end = (state_reg == ST_FL_CHECK) && !status.word_avail
                        && status.last_slot;
        cmd.ack_load  = (state_reg == ST_ACK) && status.out_free;
    end

endmodule

### sv/srrw_datapath.sv
// ============================================================================
// srrw_datapath
// Window bookkeeping, payload memory, flush counters and result register.
// ============================================================================
module srrw_datapath #(
    parameter int WINDOW_SLOTS = 4,
    parameter int PACKET_BYTES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [srrw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srrw_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [srrw_pkg::KIND_W-1:0]      m_tuser,
    output logic                             m_tlast,
    input  srrw_pkg::cmd_t                   cmd,
    output srrw_pkg::status_t                status
);

    localparam int SPAN          = WINDOW_SLOTS * PACKET_BYTES;
    localparam int WORDS_PER_PKT = PACKET_BYTES / srrw_pkg::WORD_BYTES;
    localparam int SLOT_W        = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int WPS           = 1 << srrw_pkg::WORD_IDX_W;
    localparam int MEM_DEPTH     = WINDOW_SLOTS * WPS;
    localparam int ADDR_W        = SLOT_W + srrw_pkg::WORD_IDX_W;
    localparam int OFS_W         = srrw_pkg::OFS_W;
    localparam int BYTES_W       = srrw_pkg::BYTES_W;
    localparam int IDX_W         = srrw_pkg::WORD_IDX_W;
    localparam int DATA_W        = srrw_pkg::DATA_W;
    localparam int DBYTES_W      = srrw_pkg::DBYTES_W;
    localparam int KIND_W        = srrw_pkg::KIND_W;

    logic [OFS_W-1:0]    in_seq_reg;
    logic [BYTES_W-1:0]  in_bytes_reg;
    logic                in_last_reg;
    logic [IDX_W-1:0]    in_widx_reg;
    logic [DATA_W-1:0]   in_word_reg;
    logic                in_eop_reg;

    logic [WINDOW_SLOTS-1:0] slot_filled_reg;
    logic [WINDOW_SLOTS-1:0] slot_last_reg;
    logic [BYTES_W-1:0]      slot_size_reg [WINDOW_SLOTS];
    logic [OFS_W-1:0]        window_start_reg;
    logic                    done_flag_reg;
    logic [KIND_W-1:0]       ack_kind_reg;

    logic [SLOT_W-1:0]   flush_slot_reg;
    logic [IDX_W:0]      flush_word_reg;

    logic [DATA_W-1:0]   mem [MEM_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;

    logic                m_valid_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [OFS_W-1:0]    m_ofs_reg;
    logic                m_alast_reg;
    logic [DATA_W-1:0]   m_data_reg;
    logic [DBYTES_W-1:0] m_dbytes_reg;
    logic                m_done_reg;
    logic                m_last_reg;

    logic [OFS_W-1:0]        rel;
    logic                    inwin;
    logic                    below;
    logic [SLOT_W-1:0]       slot_calc;
    logic [BYTES_W-1:0]      bytes_sat;
    logic [WINDOW_SLOTS-1:0] filled_new;
    logic [WINDOW_SLOTS-1:0] last_new;
    logic                    prefix;
    logic                    anylast;
    logic                    all_filled;
    logic                    finish;
    logic                    decide;
    logic                    store_ok;
    logic [BYTES_W-1:0]      word_base;
    logic [BYTES_W-1:0]      rem;
    logic [DBYTES_W-1:0]     emit_bytes;
    logic                    out_free;

    assign rel   = in_seq_reg - window_start_reg;
    assign inwin = rel < OFS_W'(SPAN);
    assign below = in_seq_reg < window_start_reg;

    always_comb begin
        slot_calc = '0;
        for (int j = 1; j < WINDOW_SLOTS; j++) begin
            if (rel >= OFS_W'(j * PACKET_BYTES)) begin
                slot_calc = SLOT_W'(j);
            end
        end
    end

    assign bytes_sat = (in_bytes_reg > BYTES_W'(PACKET_BYTES)) ?
                       BYTES_W'(PACKET_BYTES) : in_bytes_reg;

    always_comb begin
        for (int j = 0; j < WINDOW_SLOTS; j++) begin
            filled_new[j] = slot_filled_reg[j] || (slot_calc == SLOT_W'(j));
            last_new[j]   = (slot_calc == SLOT_W'(j)) ? in_last_reg : slot_last_reg[j];
        end
    end

    assign prefix     = (filled_new & (filled_new + 1'b1)) == '0;
    assign anylast    = |(filled_new & last_new);
    assign all_filled = &filled_new;
    assign finish     = anylast && prefix;
    assign decide     = in_eop_reg && !done_flag_reg;
    assign store_ok   = !done_flag_reg && inwin
                        && ({1'b0, in_widx_reg} < (IDX_W + 1)'(WORDS_PER_PKT));

    assign word_base  = {flush_word_reg, {(BYTES_W - IDX_W - 1){1'b0}}};
    assign rem        = slot_size_reg[flush_slot_reg] - word_base;
    assign emit_bytes = (rem > BYTES_W'(srrw_pkg::WORD_BYTES)) ?
                        DBYTES_W'(srrw_pkg::WORD_BYTES) : rem[DBYTES_W-1:0];
    assign out_free   = !m_valid_reg || m_tready;

    assign status.decide     = decide;
    assign status.flush_req  = inwin && (finish || all_filled);
    assign status.word_avail = slot_filled_reg[flush_slot_reg]
                               && (word_base < slot_size_reg[flush_slot_reg]);
    assign status.last_slot  = flush_slot_reg == SLOT_W'(WINDOW_SLOTS - 1);
    assign status.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_seq_reg   <= s_tdata[30:0];
            in_bytes_reg <= s_tdata[37:31];
            in_last_reg  <= s_tdata[38];
            in_widx_reg  <= s_tdata[41:39];
            in_word_reg  <= s_tdata[105:42];
            in_eop_reg   <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.evaluate && store_ok) begin
            mem[{slot_calc, in_widx_reg}] <= in_word_reg;
        end
        rd_data_reg <= mem[ADDR_W'({flush_slot_reg, flush_word_reg[IDX_W-1:0]})];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_filled_reg  <= '0;
            slot_last_reg    <= '0;
            for (int j = 0; j < WINDOW_SLOTS; j++) begin
                slot_size_reg[j] <= '0;
            end
            window_start_reg <= '0;
            done_flag_reg    <= 1'b0;
            ack_kind_reg     <= srrw_pkg::KIND_ACK;
            flush_slot_reg   <= '0;
            flush_word_reg   <= '0;
        end else begin
            if (cmd.evaluate) begin
                flush_slot_reg <= '0;
                flush_word_reg <= '0;
                if (decide) begin
                    ack_kind_reg <= (inwin || below) ? srrw_pkg::KIND_ACK
                                                     : srrw_pkg::KIND_REJECT;
                    if (inwin) begin
                        slot_filled_reg          <= filled_new;
                        slot_last_reg            <= last_new;
                        slot_size_reg[slot_calc] <= bytes_sat;
                        if (finish) begin
                            done_flag_reg <= 1'b1;
                        end else if (all_filled) begin
                            window_start_reg <= window_start_reg + OFS_W'(SPAN);
                        end
                    end
                end
            end
            if (cmd.word_next) begin
                flush_word_reg <= flush_word_reg + 1'b1;
            end
            if (cmd.slot_next) begin
                flush_slot_reg <= flush_slot_reg + 1'b1;
                flush_word_reg <= '0;
            end
            if (cmd.flush_end) begin
                slot_filled_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.word_next || cmd.ack_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.word_next) begin
            m_kind_reg   <= srrw_pkg::KIND_DATA;
            m_ofs_reg    <= '0;
            m_alast_reg  <= 1'b0;
            m_data_reg   <= rd_data_reg;
            m_dbytes_reg <= emit_bytes;
            m_done_reg   <= done_flag_reg;
            m_last_reg   <= 1'b0;
        end else if (cmd.ack_load) begin
            m_kind_reg   <= ack_kind_reg;
            m_ofs_reg    <= in_seq_reg;
            m_alast_reg  <= in_last_reg;
            m_data_reg   <= '0;
            m_dbytes_reg <= '0;
            m_done_reg   <= done_flag_reg;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_done_reg, m_dbytes_reg, m_data_reg, m_alast_reg, m_ofs_reg};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.word_next || cmd.ack_load) |-> (!m_valid_reg || m_tready))
        else $error("Result register loaded while a transfer was pending.");

    a_window_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        done_flag_reg |=> $stable(window_start_reg))
        else $error("Window moved after the transfer completed.");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush_end |=> (slot_filled_reg == '0))
        else $error("Slots still filled after a flush.");

    a_data_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.word_next |=> (m_dbytes_reg != '0))
        else $error("Flushed data word carries no valid bytes.");
`endif

endmodule
